/* rtl/sos_pkg.sv */
`default_nettype none

package sos_pkg;

   localparam logic [1:0] ACT_PUSH   = 2'd0;
   localparam logic [1:0] ACT_POP    = 2'd1;
   localparam logic [1:0] ACT_POP_AT = 2'd2;
   localparam logic [1:0] ACT_TOP    = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_UNDER = 2'd1;
   localparam logic [1:0] ST_OVER  = 2'd2;

   localparam int          CSR_ADDR_W       = 3;
   localparam logic        CSR_IDX_CAPACITY = 1'b0;
   localparam logic [4:0]  CAPACITY_RESET   = 5'd16;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [31:0] push_value;
      logic [2:0]         stack_index;
   } req_type;

   typedef struct packed {
      logic signed [31:0] top_value;
      logic [1:0]         status;
      logic               all_empty;
      logic               current_full;
      logic [2:0]         current_stack;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_FILL_RD,
      S_DECIDE,
      S_REPLY
   } state_type;

   typedef struct packed {
      logic       load;
      logic       step;
      logic       fill_rd;
      logic       next_stack;
      logic       push_commit;
      logic       pop_commit;
      logic       top_commit;
      logic       under_commit;
      logic       status_we;
      logic [1:0] status_code;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       walk_end;
      logic       fill_ge_cap;
      logic       fill_zero;
      logic       at_last;
      logic       advanced;
      logic       rsp_busy;
   } sts_type;

endpackage

`default_nettype wire

/* rtl/sos_csr.sv */
`default_nettype none

module sos_csr import sos_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic      [31:0]           prdata,
   output logic                       pready,
   output logic      [4:0]            capacity
);

   logic [4:0] capacity_ff;
   logic [4:0] capacity_in;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && (paddr[2] == CSR_IDX_CAPACITY);

   always_comb begin
      capacity_in = capacity_ff;
      if (wr_en) begin
         capacity_in = pwdata[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   assign prdata   = (paddr[2] == CSR_IDX_CAPACITY) ? {27'd0, capacity_ff} : 32'd0;
   assign capacity = capacity_ff;

endmodule

`default_nettype wire

/* rtl/sos_ctrl.sv */
`default_nettype none

module sos_ctrl import sos_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if ((sts.action == ACT_PUSH) || sts.walk_end) begin
               state_in = S_FILL_RD;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_FILL_RD: begin
            cmd.fill_rd = 1'b1;
            state_in    = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_REPLY;
            case (sts.action)
               ACT_PUSH: begin
                  if (sts.fill_ge_cap) begin
                     if (sts.at_last || sts.advanced) begin
                        cmd.status_we   = 1'b1;
                        cmd.status_code = ST_OVER;
                     end else begin
                        cmd.next_stack = 1'b1;
                        state_in       = S_FILL_RD;
                     end
                  end else begin
                     cmd.push_commit = 1'b1;
                  end
               end
               default: begin
                  if (sts.fill_zero) begin
                     cmd.status_we    = 1'b1;
                     cmd.status_code  = ST_UNDER;
                     cmd.under_commit = 1'b1;
                  end else if (sts.action == ACT_TOP) begin
                     cmd.top_commit = 1'b1;
                  end else begin
                     cmd.pop_commit = 1'b1;
                  end
               end
            endcase
         end
         S_REPLY: begin
            if (!sts.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/sos_dp.sv */
`default_nettype none

module sos_dp import sos_pkg::*; #(
   parameter int NUM_STACKS  = 8,
   parameter int STACK_DEPTH = 16,
   parameter int DATA_WIDTH  = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire req_type    req_data,
   input  wire cmd_type    cmd,
   output sts_type         sts,
   input  wire logic [4:0] capacity,
   input  wire logic       rsp_stall,
   output logic            rsp_valid,
   output rsp_type         rsp_data
);

   localparam int PW = $clog2(NUM_STACKS);
   localparam int FW = $clog2(STACK_DEPTH + 1);
   localparam int TW = $clog2(NUM_STACKS * STACK_DEPTH + 1);
   localparam int AW = (NUM_STACKS * STACK_DEPTH > 1) ? $clog2(NUM_STACKS * STACK_DEPTH) : 1;
   localparam int CW = (FW > 5) ? FW : 5;
   localparam int XW = PW + 3;

   req_type                  item_ff, item_in;
   logic [PW-1:0]            s_ff, s_in;
   logic                     adv_ff, adv_in;
   logic [PW-1:0]            ptr_ff, ptr_in;
   logic [FW-1:0]            cur_fill_ff, cur_fill_in;
   logic [TW-1:0]            total_ff, total_in;
   logic [NUM_STACKS-1:0]    nonempty_ff, nonempty_in;
   logic [1:0]               status_ff, status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic [FW-1:0]            fill_count_ff [NUM_STACKS];
   logic [FW-1:0]            fill_q_ff;
   logic [DATA_WIDTH-1:0]    item_store_ff [NUM_STACKS * STACK_DEPTH];
   logic [DATA_WIDTH-1:0]    item_q_ff;

   logic [FW-1:0]            fill_cur, fill_inc, fill_dec, fill_wdata;
   logic                     fill_we;
   logic [CW-1:0]            cap_x, depth_x, eff_cap;
   logic [AW-1:0]            base_addr, wr_addr, rd_addr;
   logic [XW-1:0]            idx_x, last_x;
   logic [PW-1:0]            start;
   logic [63:0]              push_ext, item_ext;
   logic [DATA_WIDTH-1:0]    item_wdata;
   logic [XW-1:0]            ptr_x;
   logic [31:0]              top_word;

   assign fill_cur = nonempty_ff[s_ff] ? fill_q_ff : '0;
   assign fill_inc = fill_cur + FW'(1);
   assign fill_dec = fill_cur - FW'(1);

   assign cap_x   = CW'(capacity);
   assign depth_x = CW'(STACK_DEPTH);
   assign eff_cap = (cap_x == '0) ? CW'(1) : ((cap_x > depth_x) ? depth_x : cap_x);

   assign base_addr = AW'(s_ff) * AW'(STACK_DEPTH);
   assign wr_addr   = base_addr + AW'(fill_cur);
   assign rd_addr   = base_addr + AW'(fill_dec);

   assign idx_x  = XW'(item_in.stack_index);
   assign last_x = XW'(NUM_STACKS - 1);

   assign push_ext   = {{32{item_ff.push_value[31]}}, item_ff.push_value};
   assign item_wdata = push_ext[DATA_WIDTH-1:0];
   assign item_ext   = 64'(item_q_ff);
   assign top_word   = item_ext[31:0];
   assign ptr_x      = XW'(ptr_ff);

   assign fill_we    = cmd.push_commit || cmd.pop_commit;
   assign fill_wdata = cmd.push_commit ? fill_inc : fill_dec;

   always_comb begin
      item_in = item_ff;
      if (cmd.load) begin
         item_in = req_data;
      end
   end

   always_comb begin
      case (req_data.action)
         ACT_POP_AT: start = (idx_x > last_x) ? last_x[PW-1:0] : idx_x[PW-1:0];
         default:    start = ptr_ff;
      endcase
   end

   always_comb begin
      s_in        = s_ff;
      adv_in      = adv_ff;
      ptr_in      = ptr_ff;
      cur_fill_in = cur_fill_ff;
      total_in    = total_ff;
      nonempty_in = nonempty_ff;
      status_in   = status_ff;
      if (cmd.load) begin
         s_in      = start;
         adv_in    = 1'b0;
         status_in = ST_OK;
      end
      if (cmd.step) begin
         s_in = s_ff - PW'(1);
      end
      if (cmd.next_stack) begin
         s_in   = s_ff + PW'(1);
         adv_in = 1'b1;
      end
      if (cmd.status_we) begin
         status_in = cmd.status_code;
      end
      if (cmd.push_commit) begin
         ptr_in            = s_ff;
         cur_fill_in       = fill_inc;
         total_in          = total_ff + TW'(1);
         nonempty_in[s_ff] = 1'b1;
      end
      if (cmd.pop_commit) begin
         total_in          = total_ff - TW'(1);
         nonempty_in[s_ff] = (fill_dec != '0);
         if (item_ff.action == ACT_POP) begin
            ptr_in      = s_ff;
            cur_fill_in = fill_dec;
         end else if (s_ff == ptr_ff) begin
            cur_fill_in = fill_dec;
         end
      end
      if (cmd.top_commit || (cmd.under_commit && (item_ff.action != ACT_POP_AT))) begin
         ptr_in      = s_ff;
         cur_fill_in = fill_cur;
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in         = 1'b1;
         rsp_in.top_value     = ((item_ff.action == ACT_TOP) && (status_ff == ST_OK)) ?
                                top_word : 32'sd0;
         rsp_in.status        = status_ff;
         rsp_in.all_empty     = (total_ff == '0);
         rsp_in.current_full  = (CW'(cur_fill_ff) >= eff_cap);
         rsp_in.current_stack = ptr_x[2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         adv_ff       <= 1'b0;
         ptr_ff       <= '0;
         cur_fill_ff  <= '0;
         total_ff     <= '0;
         nonempty_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         s_ff         <= '0;
      end else begin
         adv_ff       <= adv_in;
         ptr_ff       <= ptr_in;
         cur_fill_ff  <= cur_fill_in;
         total_ff     <= total_in;
         nonempty_ff  <= nonempty_in;
         rsp_valid_ff <= rsp_valid_in;
         s_ff         <= s_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_count_ff[s_ff] <= fill_wdata;
      end
      if (cmd.fill_rd) begin
         fill_q_ff <= fill_count_ff[s_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push_commit) begin
         item_store_ff[wr_addr] <= item_wdata;
      end
      if (cmd.top_commit) begin
         item_q_ff <= item_store_ff[rd_addr];
      end
   end

   assign sts.action      = item_ff.action;
   assign sts.walk_end    = (s_ff == '0) || nonempty_ff[s_ff];
   assign sts.fill_ge_cap = (CW'(fill_cur) >= eff_cap);
   assign sts.fill_zero   = (fill_cur == '0);
   assign sts.at_last     = (s_ff == PW'(NUM_STACKS - 1));
   assign sts.advanced    = adv_ff;
   assign sts.rsp_busy    = rsp_valid_ff && rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

/* rtl/set_of_stacks_with_pop_at.sv */
// Channel   Direction  Handshake                 Beat
// req_      in         req_valid / req_stall     req_type: action, push_value, stack_index
// rsp_      out        rsp_valid / rsp_stall     rsp_type: top_value, status, flags, stack
// csr       in/out     psel, penable, pwrite     stack_capacity at byte address 0
//
// One beat is taken at a time. A push passes the idle, walk, fill read, decide and reply
// states, with fill read and decide again when it moves on to the next stack. Pop, pop-at
// and read-top also step back over empty stacks in the walk, one nonempty flag per cycle.
// Reset is synchronous and clears the nonempty flags, so every fill count reads as zero.
// A new request beat is taken while the previous result beat is stalled; that request
// waits in its final cycle until the output register is free.
`default_nettype none

module set_of_stacks_with_pop_at import sos_pkg::*; #(
   parameter int NUM_STACKS  = 8,
   parameter int STACK_DEPTH = 16,
   parameter int DATA_WIDTH  = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic      [31:0]           prdata,
   output logic                       pready
);

   cmd_type    cmd;
   sts_type    sts;
   logic [4:0] capacity;

   sos_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .capacity (capacity)
   );

   sos_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   sos_dp #(
      .NUM_STACKS  (NUM_STACKS),
      .STACK_DEPTH (STACK_DEPTH),
      .DATA_WIDTH  (DATA_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .capacity  (capacity),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* test/tb_set_of_stacks_with_pop_at.sv */
`timescale 1ns / 100ps

module tb_set_of_stacks_with_pop_at;
   import sos_pkg::*;

   localparam int NUM_STACKS  = 8;
   localparam int STACK_DEPTH = 16;
   localparam int IDLE_LIMIT  = 2000;

   class stack_scoreboard;
      logic signed [31:0] item_store [NUM_STACKS][STACK_DEPTH];
      int unsigned        fill_count [NUM_STACKS];
      int unsigned        cur_stack;
      int unsigned        total_items;
      int unsigned        capacity;
      rsp_type            pending_replies [$];
      int unsigned        errors;
      int unsigned        requests;
      int unsigned        replies;
      int unsigned        underflows;
      int unsigned        overflows;

      function new();
         foreach (fill_count[i]) fill_count[i] = 0;
         cur_stack   = 0;
         total_items = 0;
         capacity    = 32'(CAPACITY_RESET);
         errors      = 0;
         requests    = 0;
         replies     = 0;
         underflows  = 0;
         overflows   = 0;
      endfunction

      function void set_capacity(logic [4:0] value);
         capacity = 32'(value);
      endfunction

      function int pending();
         return pending_replies.size();
      endfunction

      function int unsigned walk_back_from(int unsigned s);
         while (s > 0 && fill_count[s] == 0) s--;
         return s;
      endfunction

      function void note_request(req_type r);
         rsp_type     e;
         int unsigned s;
         int unsigned cap;
         cap = (capacity < 1) ? 1 : ((capacity > STACK_DEPTH) ? STACK_DEPTH : capacity);
         e = '0;
         e.status = ST_OK;
         requests++;
         case (r.action)
            ACT_PUSH: begin
               s = cur_stack;
               if (fill_count[s] >= cap) begin
                  if (s + 1 >= NUM_STACKS) e.status = ST_OVER;
                  else s++;
               end
               if (e.status == ST_OK && fill_count[s] >= cap) e.status = ST_OVER;
               if (e.status == ST_OK) begin
                  cur_stack = s;
                  item_store[s][fill_count[s]] = r.push_value;
                  fill_count[s]++;
                  total_items++;
               end
            end
            ACT_POP, ACT_TOP: begin
               s = walk_back_from(cur_stack);
               cur_stack = s;
               if (fill_count[s] == 0) begin
                  e.status = ST_UNDER;
               end else if (r.action == ACT_POP) begin
                  fill_count[s]--;
                  total_items--;
               end else begin
                  e.top_value = item_store[s][fill_count[s] - 1];
               end
            end
            default: begin
               s = (r.stack_index >= NUM_STACKS) ? NUM_STACKS - 1 : r.stack_index;
               s = walk_back_from(s);
               if (fill_count[s] == 0) begin
                  e.status = ST_UNDER;
               end else begin
                  fill_count[s]--;
                  total_items--;
               end
            end
         endcase
         if (e.status == ST_UNDER) underflows++;
         if (e.status == ST_OVER) overflows++;
         e.all_empty     = (total_items == 0);
         e.current_full  = (fill_count[cur_stack] >= cap);
         e.current_stack = 3'(cur_stack);
         pending_replies.push_back(e);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         if (errors <= 40)
            $display("%0t mismatch in %s: got 0x%h, expected 0x%h", $time, what, got, want);
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         replies++;
         if (pending_replies.size() == 0) begin
            report("result beat with nothing expected", got.top_value, 32'd0);
         end else begin
            want = pending_replies.pop_front();
            if (got.top_value !== want.top_value)
               report("top_value", got.top_value, want.top_value);
            if (got.status !== want.status)
               report("status", 32'(got.status), 32'(want.status));
            if (got.all_empty !== want.all_empty)
               report("all_empty", 32'(got.all_empty), 32'(want.all_empty));
            if (got.current_full !== want.current_full)
               report("current_full", 32'(got.current_full), 32'(want.current_full));
            if (got.current_stack !== want.current_stack)
               report("current_stack", 32'(got.current_stack), 32'(want.current_stack));
         end
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   stack_scoreboard sb;
   bit              req_calm;
   int unsigned     settings_done;

   set_of_stacks_with_pop_at u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 96) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   function automatic req_type make_req(logic [1:0] action, logic [31:0] value,
                                        logic [2:0] index);
      req_type r;
      r.action      = action;
      r.push_value  = value;
      r.stack_index = index;
      return r;
   endfunction

   // All driving tasks are entered and left just after a falling edge.
   task automatic send_req(req_type r);
      int gap;
      gap = req_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      @(negedge clock);
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   task automatic csr_write(logic [4:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(4 * int'(CSR_IDX_CAPACITY));
      pwdata  <= 32'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_capacity(value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_read_check(logic [4:0] want);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= CSR_ADDR_W'(4 * int'(CSR_IDX_CAPACITY));
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[4:0] !== want)
         sb.report("stack_capacity readback", 32'(prdata[4:0]), 32'(want));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic change_capacity(logic [4:0] value);
      drain_replies();
      repeat (12) @(negedge clock);
      csr_write(value);
      @(negedge clock);
      csr_read_check(value);
      settings_done++;
   endtask

   task automatic run_random(int count);
      int          push_pct;
      int          roll;
      req_type     r;
      logic [31:0] value;
      push_pct = 55;
      for (int i = 0; i < count; i++) begin
         if (i % 30 == 0) begin
            case ($urandom_range(0, 3))
               0:       push_pct = 85;
               1:       push_pct = 20;
               2:       push_pct = 55;
               default: push_pct = 97;
            endcase
            req_calm = ($urandom_range(0, 3) == 0);
         end
         if ($urandom_range(0, 59) == 0) drain_replies();
         value = $urandom;
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
               0:       value = 32'h7fff_ffff;
               1:       value = 32'h8000_0000;
               2:       value = 32'h0000_0000;
               default: value = 32'hffff_ffff;
            endcase
         end
         roll = $urandom_range(0, 99);
         if (roll < push_pct) begin
            r = make_req(ACT_PUSH, value, 3'($urandom_range(0, 7)));
         end else begin
            case ($urandom_range(0, 2))
               0:       r = make_req(ACT_POP, value, 3'($urandom_range(0, 7)));
               1:       r = make_req(ACT_POP_AT, value, 3'($urandom_range(0, 7)));
               default: r = make_req(ACT_TOP, value, 3'($urandom_range(0, 7)));
            endcase
         end
         send_req(r);
      end
      req_calm = 1'b0;
   endtask

   // Result beats are checked at the rising edge; stall changes at the falling edge.
   initial begin
      int run_left;
      int stall_left;
      int idle_cycles;
      rsp_stall   = 1'b0;
      run_left    = 0;
      stall_left  = 0;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
               idle_cycles = 0;
            else
               idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("%0t no beat accepted for %0d cycles", $time, IDLE_LIMIT);
               $display("set_of_stacks_with_pop_at verification failed");
               $finish;
            end
         end
         @(negedge clock);
         if (stall_left == 0 && run_left == 0) begin
            run_left   = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                      : $urandom_range(1, 12);
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 4);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            run_left--;
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      sb            = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      req_calm      = 1'b0;
      settings_done = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      csr_read_check(CAPACITY_RESET);
      change_capacity(5'd16);
      send_req(make_req(ACT_POP, 32'h0, 3'd0));
      send_req(make_req(ACT_TOP, 32'hffff_ffff, 3'd7));
      send_req(make_req(ACT_POP_AT, 32'h0, 3'd7));
      send_req(make_req(ACT_PUSH, 32'h7fff_ffff, 3'd0));
      send_req(make_req(ACT_PUSH, 32'h8000_0000, 3'd5));
      send_req(make_req(ACT_PUSH, 32'h0000_0000, 3'd2));
      send_req(make_req(ACT_PUSH, 32'hffff_ffff, 3'd7));
      send_req(make_req(ACT_TOP, 32'h0, 3'd0));
      send_req(make_req(ACT_POP_AT, 32'h0, 3'd5));
      send_req(make_req(ACT_POP, 32'h0, 3'd0));
      send_req(make_req(ACT_TOP, 32'h0, 3'd0));
      send_req(make_req(ACT_PUSH, 32'h1234_5678, 3'd1));

      // Stack 0 now holds more items than the new capacity allows.
      change_capacity(5'd2);
      send_req(make_req(ACT_TOP, 32'h0, 3'd0));
      send_req(make_req(ACT_PUSH, 32'h5555_aaaa, 3'd0));
      send_req(make_req(ACT_PUSH, 32'haaaa_5555, 3'd0));

      change_capacity(5'd1);
      repeat (6) send_req(make_req(ACT_PUSH, $urandom, 3'($urandom_range(0, 7))));
      send_req(make_req(ACT_PUSH, 32'hdead_beef, 3'd0));
      send_req(make_req(ACT_POP_AT, 32'h0, 3'd3));
      send_req(make_req(ACT_POP_AT, 32'h0, 3'd3));
      send_req(make_req(ACT_POP, 32'h0, 3'd0));

      change_capacity(5'd0);
      run_random(100);
      change_capacity(5'd31);
      run_random(150);
      change_capacity(5'd3);
      run_random(100);
      change_capacity(5'd16);
      run_random(120);
      change_capacity(5'($urandom_range(0, 31)));
      run_random(100);
      change_capacity(5'd1);
      run_random(80);
      change_capacity(5'd7);
      run_random(100);

      drain_replies();
      repeat (20) @(negedge clock);
      if (sb.pending() != 0) sb.report("results still expected at end", sb.pending(), 0);
      $display("Checked %0d result beats for %0d request beats over %0d capacity settings.",
               sb.replies, sb.requests, settings_done);
      $display("Predicted %0d underflows and %0d overflows; %0d mismatches.",
               sb.underflows, sb.overflows, sb.errors);
      if (sb.errors == 0) begin
         $display("set_of_stacks_with_pop_at verification clean");
      end else begin
         $display("set_of_stacks_with_pop_at verification failed");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/sos_pkg.sv
rtl/sos_csr.sv
rtl/sos_ctrl.sv
rtl/sos_dp.sv
rtl/set_of_stacks_with_pop_at.sv
test/tb_set_of_stacks_with_pop_at.sv
